// ===== sv/nd_array_part_splitter_defines.svh =====
// assertion macros for the part splitter
`ifndef ND_ARRAY_PART_SPLITTER_DEFINES_SVH
`define ND_ARRAY_PART_SPLITTER_DEFINES_SVH

// property checked on every rising edge outside reset
`define SPL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("part splitter assertion failed");

// property checked on every rising edge, reset included
`define SPL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("part splitter check failed");

`endif

// ===== sv/spl_pkg.sv =====
package spl_pkg;

   localparam int DIMS          = 4;
   localparam int DEF_MAX_DIMS  = 4;
   localparam int DEF_MAX_PARTS = 64;

   // register indexes
   localparam logic [2:0] CSR_NUM_DIMS = 3'd0;
   localparam logic [2:0] CSR_DIM_0    = 3'd1;
   localparam logic [2:0] CSR_DIM_1    = 3'd2;
   localparam logic [2:0] CSR_DIM_2    = 3'd3;
   localparam logic [2:0] CSR_DIM_3    = 3'd4;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic save;
      logic emit_run;
      logic emit_leaf;
      logic emit_err;
      logic descend;
      logic ascend;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic leaf;
      logic fits;
      logic div_done;
      logic run_end;
      logic lvl_zero;
      logic idx_lt_m;
   } sts_type;

endpackage

// ===== sv/spl_dp.sv =====
`include "nd_array_part_splitter_defines.svh"

module spl_dp #(
   parameter int MAX_DIMS  = spl_pkg::DEF_MAX_DIMS,
   parameter int MAX_PARTS = spl_pkg::DEF_MAX_PARTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic [6:0]       req_part_count,
   input  spl_pkg::cmd_type cmd,
   output spl_pkg::sts_type sts,
   output logic             rsp_valid,
   output logic [5:0]       rsp_part_index,
   output logic [2:0]       rsp_slice_count,
   output logic [31:0]      rsp_slice_start_0,
   output logic [31:0]      rsp_slice_stop_0,
   output logic [31:0]      rsp_slice_start_1,
   output logic [31:0]      rsp_slice_stop_1,
   output logic [31:0]      rsp_slice_start_2,
   output logic [31:0]      rsp_slice_stop_2,
   output logic [31:0]      rsp_slice_start_3,
   output logic [31:0]      rsp_slice_stop_3,
   output logic             rsp_last_part,
   output logic             rsp_status
);

   localparam int DIMS = spl_pkg::DIMS;

   // configuration
   logic [2:0]  num_dims_ff;
   logic [31:0] dim_ff [DIMS];

   // traversal state
   logic [2:0]  depth_ff;
   logic [2:0]  lvl_ff;
   logic [6:0]  parts_ff [DIMS];
   logic [31:0] quo_lvl_ff [DIMS];
   logic [5:0]  rem_lvl_ff [DIMS];
   logic [5:0]  idx_ff [DIMS];
   logic [6:0]  run_i_ff;
   logic [31:0] acc_ff;
   logic [5:0]  emitted_ff;

   // divider
   logic [31:0] dvd_ff;
   logic [31:0] drem_ff;
   logic [31:0] dsr_ff;
   logic [4:0]  dcnt_ff;

   // result register
   logic        rsp_valid_ff;
   logic [5:0]  rsp_index_ff;
   logic [2:0]  rsp_count_ff;
   logic [31:0] rsp_start_ff [DIMS];
   logic [31:0] rsp_stop_ff [DIMS];
   logic        rsp_last_ff;
   logic        rsp_status_ff;

   logic [1:0]  li;
   logic [1:0]  pl;
   logic [31:0] m_cur;
   logic [6:0]  n_cur;
   logic [2:0]  req_depth;
   logic        bad_dim;
   logic [6:0]  n_sat;
   logic        run_extra;
   logic [31:0] run_stop;
   logic [6:0]  share;
   logic        anc_last;
   logic [32:0] trial;
   logic [31:0] start_in [DIMS];
   logic [31:0] stop_in [DIMS];
   logic        emit_any;

   assign li    = lvl_ff[1:0];
   assign pl    = li - 2'd1;
   assign m_cur = dim_ff[li];
   assign n_cur = parts_ff[li];

   assign req_depth = (num_dims_ff > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : num_dims_ff;
   assign n_sat     = (req_part_count > 7'(MAX_PARTS)) ? 7'(MAX_PARTS) : req_part_count;

   always_comb begin
      bad_dim = 1'b0;
      for (int d = 0; d < DIMS; d++) begin
         if ((3'(d) < req_depth) && (dim_ff[d] == 32'd0)) begin
            bad_dim = 1'b1;
         end
      end
   end

   assign run_extra = run_i_ff < {1'b0, rem_lvl_ff[li]};
   assign run_stop  = acc_ff + quo_lvl_ff[li] + {31'd0, run_extra};
   assign share     = quo_lvl_ff[li][6:0] + {6'd0, (idx_ff[li] < rem_lvl_ff[li])};

   // every enclosing level sits on its last index
   always_comb begin
      anc_last = 1'b1;
      for (int d = 0; d < DIMS; d++) begin
         if ((3'(d) < lvl_ff) && (({26'd0, idx_ff[d]} + 32'd1) != dim_ff[d])) begin
            anc_last = 1'b0;
         end
      end
   end

   assign trial = {drem_ff, dvd_ff[31]} - {1'b0, dsr_ff};

   assign sts.bad      = (req_part_count == 7'd0) || bad_dim;
   assign sts.leaf     = lvl_ff >= depth_ff;
   assign sts.fits     = {25'd0, n_cur} <= m_cur;
   assign sts.div_done = dcnt_ff == 5'd0;
   assign sts.run_end  = run_i_ff == (n_cur - 7'd1);
   assign sts.lvl_zero = lvl_ff == 3'd0;
   assign sts.idx_lt_m = {26'd0, idx_ff[li]} < m_cur;

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         start_in[d] = 32'd0;
         stop_in[d]  = 32'd0;
         if (!cmd.emit_err) begin
            if (3'(d) < lvl_ff) begin
               start_in[d] = {26'd0, idx_ff[d]};
               stop_in[d]  = {26'd0, idx_ff[d]} + 32'd1;
            end else if (cmd.emit_run && (3'(d) == lvl_ff)) begin
               start_in[d] = acc_ff;
               stop_in[d]  = run_stop;
            end
         end
      end
   end

   assign emit_any = cmd.emit_run || cmd.emit_leaf || cmd.emit_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= 3'd1;
         for (int d = 0; d < DIMS; d++) begin
            dim_ff[d] <= 32'd1;
         end
      end else if (csr_valid) begin
         case (csr_index)
            spl_pkg::CSR_NUM_DIMS: num_dims_ff <= csr_wdata[2:0];
            spl_pkg::CSR_DIM_0:    dim_ff[0]   <= csr_wdata;
            spl_pkg::CSR_DIM_1:    dim_ff[1]   <= csr_wdata;
            spl_pkg::CSR_DIM_2:    dim_ff[2]   <= csr_wdata;
            spl_pkg::CSR_DIM_3:    dim_ff[3]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff       <= 3'd0;
         depth_ff     <= 3'd0;
         emitted_ff   <= 6'd0;
         dcnt_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_any;
         if (cmd.load) begin
            lvl_ff      <= 3'd0;
            depth_ff    <= req_depth;
            emitted_ff  <= 6'd0;
            parts_ff[0] <= n_sat;
         end
         if (cmd.div_start) begin
            dvd_ff  <= sts.fits ? m_cur : {25'd0, n_cur};
            dsr_ff  <= sts.fits ? {25'd0, n_cur} : m_cur;
            drem_ff <= 32'd0;
            dcnt_ff <= 5'd31;
         end
         if (cmd.div_step) begin
            if (!trial[32]) begin
               drem_ff <= trial[31:0];
               dvd_ff  <= {dvd_ff[30:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[30:0], dvd_ff[31]};
               dvd_ff  <= {dvd_ff[30:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 5'd1;
         end
         if (cmd.save) begin
            quo_lvl_ff[li] <= dvd_ff;
            rem_lvl_ff[li] <= drem_ff[5:0];
            idx_ff[li]     <= 6'd0;
            run_i_ff       <= 7'd0;
            acc_ff         <= 32'd0;
         end
         if (cmd.emit_run) begin
            run_i_ff <= run_i_ff + 7'd1;
            acc_ff   <= run_stop;
         end
         if (cmd.emit_run || cmd.emit_leaf) begin
            emitted_ff <= emitted_ff + 6'd1;
         end
         if (cmd.descend) begin
            if (lvl_ff < 3'(DIMS - 1)) begin
               parts_ff[li + 2'd1] <= share;
            end
            lvl_ff <= lvl_ff + 3'd1;
         end
         if (cmd.ascend) begin
            lvl_ff     <= lvl_ff - 3'd1;
            idx_ff[pl] <= idx_ff[pl] + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         rsp_index_ff  <= cmd.emit_err ? 6'd0 : emitted_ff;
         rsp_count_ff  <= cmd.emit_err ? 3'd0 : (cmd.emit_run ? lvl_ff + 3'd1 : lvl_ff);
         rsp_last_ff   <= cmd.emit_err || (anc_last && (cmd.emit_leaf || sts.run_end));
         rsp_status_ff <= cmd.emit_err;
         for (int d = 0; d < DIMS; d++) begin
            rsp_start_ff[d] <= start_in[d];
            rsp_stop_ff[d]  <= stop_in[d];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_part_index    = rsp_index_ff;
   assign rsp_slice_count   = rsp_count_ff;
   assign rsp_slice_start_0 = rsp_start_ff[0];
   assign rsp_slice_stop_0  = rsp_stop_ff[0];
   assign rsp_slice_start_1 = rsp_start_ff[1];
   assign rsp_slice_stop_1  = rsp_stop_ff[1];
   assign rsp_slice_start_2 = rsp_start_ff[2];
   assign rsp_slice_stop_2  = rsp_stop_ff[2];
   assign rsp_slice_start_3 = rsp_start_ff[3];
   assign rsp_slice_stop_3  = rsp_stop_ff[3];
   assign rsp_last_part     = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   // a rejected request is always its own last word
   `SPL_ASSERT(a_err_last, (rsp_valid_ff && rsp_status_ff) |-> rsp_last_ff)
   // the walk never goes below the configured depth
   `SPL_ASSERT(a_lvl_depth, lvl_ff <= depth_ff)

endmodule

// ===== sv/spl_ctrl.sv =====
`include "nd_array_part_splitter_defines.svh"

module spl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spl_pkg::sts_type sts,
   output spl_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ENTER = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_SAVE  = 3'd3;
   localparam logic [2:0] S_RUN   = 3'd4;
   localparam logic [2:0] S_DESC  = 3'd5;
   localparam logic [2:0] S_ASC   = 3'd6;
   localparam logic [2:0] S_CHECK = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (sts.bad) begin
                  cmd.emit_err = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_ENTER;
               end
            end
         end
         S_ENTER: begin
            if (sts.leaf) begin
               cmd.emit_leaf = 1'b1;
               state_in      = S_ASC;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_SAVE;
            end
         end
         S_SAVE: begin
            cmd.save = 1'b1;
            state_in = sts.fits ? S_RUN : S_DESC;
         end
         S_RUN: begin
            cmd.emit_run = 1'b1;
            if (sts.run_end) begin
               state_in = S_ASC;
            end
         end
         S_DESC: begin
            cmd.descend = 1'b1;
            state_in    = S_ENTER;
         end
         S_ASC: begin
            if (sts.lvl_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.ascend = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = sts.idx_lt_m ? S_DESC : S_ASC;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   // a good request always starts the walk
   `SPL_ASSERT(a_start_walk, (state_ff == S_IDLE && start && !sts.bad) |=> (state_ff == S_ENTER))
   // at most one word is produced per cycle
   `SPL_ASSERT(a_one_emit, $onehot0({cmd.emit_run, cmd.emit_leaf, cmd.emit_err}))

endmodule

// ===== sv/nd_array_part_splitter.sv =====
// near-equal part splitter for an array of up to four outer dimensions
// configuration: csr_valid/csr_ready write channel, csr_index picks the register
//   (0 num_dims, 1..4 dim sizes), csr_wdata the value; csr_ready is always high,
//   write only while busy is low
// request: a word is taken when start is high and busy is low; req_part_count
//   is the number of parts asked for (saturated to MAX_PARTS)
// results: one word per part on the rsp_ ports, marked by rsp_valid for one
//   cycle; rsp_last_part flags the final word of a request
// the receiver cannot stall, words appear whenever they are ready
// a zero part count or a zero size among the used dimensions gives a single
//   word with rsp_status set in the cycle after the request, and busy stays low
// walk: the walk visits levels depth first; every visited level that is not a leaf
//   runs a set-up, 32 shift-subtract steps and a save, a cut level then gives one
//   part per cycle, a shared level passes through ascend, check and descend for each
//   index on top of its children; with no dimensions the walk gives its one leaf
//   word from the enter state and goes idle through the ascend state
// the next request is taken once busy falls
// reset: configuration returns to one dimension of size one, walk goes idle
module nd_array_part_splitter #(
   parameter int MAX_DIMS  = spl_pkg::DEF_MAX_DIMS,
   parameter int MAX_PARTS = spl_pkg::DEF_MAX_PARTS
) (
   input  logic        clock,
   input  logic        reset,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [6:0]  req_part_count,
   // result channel
   output logic        rsp_valid,
   output logic [5:0]  rsp_part_index,
   output logic [2:0]  rsp_slice_count,
   output logic [31:0] rsp_slice_start_0,
   output logic [31:0] rsp_slice_stop_0,
   output logic [31:0] rsp_slice_start_1,
   output logic [31:0] rsp_slice_stop_1,
   output logic [31:0] rsp_slice_start_2,
   output logic [31:0] rsp_slice_stop_2,
   output logic [31:0] rsp_slice_start_3,
   output logic [31:0] rsp_slice_stop_3,
   output logic        rsp_last_part,
   output logic        rsp_status
);

   spl_pkg::cmd_type cmd;
   spl_pkg::sts_type sts;

   // registers always take a write
   assign csr_ready = 1'b1;

   // sequencer for the depth-first walk
   spl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // level stack, divider, run counter and result register
   spl_dp #(
      .MAX_DIMS  (MAX_DIMS),
      .MAX_PARTS (MAX_PARTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_part_count    (req_part_count),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_part_index    (rsp_part_index),
      .rsp_slice_count   (rsp_slice_count),
      .rsp_slice_start_0 (rsp_slice_start_0),
      .rsp_slice_stop_0  (rsp_slice_stop_0),
      .rsp_slice_start_1 (rsp_slice_start_1),
      .rsp_slice_stop_1  (rsp_slice_stop_1),
      .rsp_slice_start_2 (rsp_slice_start_2),
      .rsp_slice_stop_2  (rsp_slice_stop_2),
      .rsp_slice_start_3 (rsp_slice_start_3),
      .rsp_slice_stop_3  (rsp_slice_stop_3),
      .rsp_last_part     (rsp_last_part),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== tb/nd_array_part_splitter_tb.sv =====
`timescale 1ns / 100ps

module nd_array_part_splitter_tb;

   localparam int  LIMIT_PARTS = 64;
   localparam int  LIMIT_DIMS  = 4;
   localparam bit  STATUS_OK   = 1'b0;
   localparam bit  STATUS_BAD  = 1'b1;
   localparam int  STALL_LIMIT = 20000;

   // one result word as it leaves the splitter
   typedef struct {
      bit [5:0]  part_index;
      bit [2:0]  slice_count;
      bit [31:0] start_at [4];
      bit [31:0] stop_at [4];
      bit        last_part;
      bit        status;
   } part_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [6:0]  req_part_count = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_part_index;
   logic [2:0]  rsp_slice_count;
   logic [31:0] rsp_slice_start_0, rsp_slice_stop_0, rsp_slice_start_1, rsp_slice_stop_1;
   logic [31:0] rsp_slice_start_2, rsp_slice_stop_2, rsp_slice_start_3, rsp_slice_stop_3;
   logic        rsp_last_part;
   logic        rsp_status;

   nd_array_part_splitter u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .start(start), .busy(busy), .req_part_count(req_part_count),
      .rsp_valid(rsp_valid), .rsp_part_index(rsp_part_index),
      .rsp_slice_count(rsp_slice_count),
      .rsp_slice_start_0(rsp_slice_start_0), .rsp_slice_stop_0(rsp_slice_stop_0),
      .rsp_slice_start_1(rsp_slice_start_1), .rsp_slice_stop_1(rsp_slice_stop_1),
      .rsp_slice_start_2(rsp_slice_start_2), .rsp_slice_stop_2(rsp_slice_stop_2),
      .rsp_slice_start_3(rsp_slice_start_3), .rsp_slice_stop_3(rsp_slice_stop_3),
      .rsp_last_part(rsp_last_part), .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   // shadow of the configuration registers
   bit [2:0]  cfg_dims = 3'd1;
   bit [31:0] cfg_size [4] = '{32'd1, 32'd1, 32'd1, 32'd1};

   // predictor state: index chosen at each level on the way down
   bit [31:0]     walk_index [4];
   int            parts_made;
   part_word_type expected_parts [$];
   bit [6:0]      pending_counts [$];

   int fail_count   = 0;
   int request_seen = 0;
   int parts_seen   = 0;
   int reject_seen  = 0;
   int deep_seen    = 0;

   // one part: unit slices above lvl, plus the run at lvl if there is one
   function automatic void add_part(int lvl, bit has_run, longint unsigned run_lo,
                                    longint unsigned run_hi);
      part_word_type w;
      int d;
      if (parts_made >= LIMIT_PARTS) return;
      w.part_index = parts_made[5:0];
      w.last_part  = 1'b0;
      w.status     = STATUS_OK;
      for (d = 0; d < 4; d++) begin
         w.start_at[d] = '0;
         w.stop_at[d]  = '0;
      end
      for (d = 0; d < lvl && d < LIMIT_DIMS; d++) begin
         w.start_at[d] = walk_index[d];
         w.stop_at[d]  = walk_index[d] + 32'd1;
      end
      if (has_run && lvl < LIMIT_DIMS) begin
         w.start_at[lvl] = run_lo[31:0];
         w.stop_at[lvl]  = run_hi[31:0];
         d = lvl + 1;
      end
      w.slice_count = d[2:0];
      expected_parts.push_back(w);
      parts_made++;
   endfunction

   // depth-first split of n parts from level lvl downwards
   function automatic void split_from(int lvl, longint unsigned n, int depth);
      longint unsigned m, q, r, i, lo, hi;
      if (lvl >= depth || lvl >= LIMIT_DIMS) begin
         add_part(lvl, 1'b0, 0, 0);
         return;
      end
      if (lvl > 0) deep_seen++;
      m = cfg_size[lvl];
      if (n <= m) begin
         q = m / n;
         r = m % n;
         for (i = 0; i < n; i++) begin
            lo = (i < r) ? i * (q + 1) : r + i * q;
            hi = (i < r) ? (i + 1) * (q + 1) : r + (i + 1) * q;
            add_part(lvl, 1'b1, lo, hi);
         end
      end else begin
         q = n / m;
         r = n % m;
         for (i = 0; i < m; i++) begin
            walk_index[lvl] = i[31:0];
            split_from(lvl + 1, (i < r) ? q + 1 : q, depth);
         end
      end
   endfunction

   // expected words for one accepted request word
   function automatic void predict_split(bit [6:0] count);
      part_word_type w;
      int depth, d;
      bit bad;
      depth = (cfg_dims > LIMIT_DIMS) ? LIMIT_DIMS : cfg_dims;
      bad = (count == 0);
      for (d = 0; d < depth; d++)
         if (cfg_size[d] == 0) bad = 1'b1;
      parts_made = 0;
      if (bad) begin
         w.part_index  = '0;
         w.slice_count = '0;
         for (d = 0; d < 4; d++) begin
            w.start_at[d] = '0;
            w.stop_at[d]  = '0;
         end
         w.last_part = 1'b1;
         w.status    = STATUS_BAD;
         expected_parts.push_back(w);
         reject_seen++;
         return;
      end
      split_from(0, (count > LIMIT_PARTS) ? LIMIT_PARTS : count, depth);
      if (parts_made > 0) expected_parts[expected_parts.size() - 1].last_part = 1'b1;
   endfunction

   // driver: request words go out in bursts with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            // word taken at this edge
            predict_split(req_part_count);
            request_seen++;
            void'(pending_counts.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_counts.size() > 0) begin
            start          <= 1'b1;
            req_part_count <= pending_counts[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed word against the oldest expectation
   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      part_word_type w;
      if (!reset && rsp_valid) begin
         if (expected_parts.size() == 0) begin
            $error("result word with nothing expected, part_index %0d", rsp_part_index);
            fail_count++;
         end else begin
            w = expected_parts.pop_front();
            parts_seen++;
            check_field("part_index", w.part_index, rsp_part_index);
            check_field("slice_count", w.slice_count, rsp_slice_count);
            check_field("slice_start_0", w.start_at[0], rsp_slice_start_0);
            check_field("slice_stop_0", w.stop_at[0], rsp_slice_stop_0);
            check_field("slice_start_1", w.start_at[1], rsp_slice_start_1);
            check_field("slice_stop_1", w.stop_at[1], rsp_slice_stop_1);
            check_field("slice_start_2", w.start_at[2], rsp_slice_start_2);
            check_field("slice_stop_2", w.stop_at[2], rsp_slice_stop_2);
            check_field("slice_start_3", w.start_at[3], rsp_slice_start_3);
            check_field("slice_stop_3", w.stop_at[3], rsp_slice_stop_3);
            check_field("last_part", w.last_part, rsp_last_part);
            check_field("status", w.status, rsp_status);
         end
      end
   end

   // watchdog: cycles in a row with no word moving anywhere
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_parts.size());
         $display("nd_array_part_splitter_tb: FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == spl_pkg::CSR_NUM_DIMS) cfg_dims = value[2:0];
      else cfg_size[2'(idx - spl_pkg::CSR_DIM_0)] = value;
   endtask

   // the sender holds off until every word has come back, then the walk gets to settle
   task automatic drain();
      while (pending_counts.size() > 0 || start || expected_parts.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_shape(logic [2:0] dims, logic [31:0] s0, logic [31:0] s1,
                            logic [31:0] s2, logic [31:0] s3);
      drain();
      write_reg(spl_pkg::CSR_NUM_DIMS, {29'd0, dims});
      write_reg(spl_pkg::CSR_DIM_0, s0);
      write_reg(spl_pkg::CSR_DIM_1, s1);
      write_reg(spl_pkg::CSR_DIM_2, s2);
      write_reg(spl_pkg::CSR_DIM_3, s3);
   endtask

   function automatic logic [31:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(11, 70);
         2:       return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 19))
         0:       return 7'd0;
         1:       return 7'($urandom_range(65, 127));
         2:       return 7'd64;
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      logic [31:0] s [4];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset shape: one dimension of size one; zero, one, limit and saturated counts
      pending_counts = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
      // no dimensions at all
      set_shape(3'd0, 32'd5, 32'd5, 32'd5, 32'd5);
      pending_counts = '{7'd1, 7'd64};
      // four small dimensions, parts spread over indices
      set_shape(3'd4, 32'd2, 32'd3, 32'd1, 32'd2);
      pending_counts = '{7'd5, 7'd13, 7'd64, 7'd127};
      // huge sizes, runs reach the top of the range
      set_shape(3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      pending_counts = '{7'd1, 7'd7, 7'd64};
      // num_dims beyond four saturates
      set_shape(3'd7, 32'd1, 32'd2, 32'd2, 32'd3);
      pending_counts = '{7'd12, 7'd64};
      // a zero size among the used dimensions rejects the request
      set_shape(3'd3, 32'd4, 32'd0, 32'd4, 32'd0);
      pending_counts = '{7'd8, 7'd0};
      // zero size just past the used dimensions is harmless
      set_shape(3'd1, 32'd3, 32'd0, 32'd0, 32'd0);
      pending_counts = '{7'd2, 7'd9};

      // random shapes, about thirty requests each
      for (int ph = 0; ph < 12; ph++) begin
         for (int d = 0; d < 4; d++) begin
            s[d] = pick_size();
            if ($urandom_range(0, 29) == 0) s[d] = 32'd0;
         end
         set_shape(3'($urandom_range(0, 7)), s[0], s[1], s[2], s[3]);
         for (int k = 0; k < 30; k++) pending_counts.push_back(pick_count());
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d requests, %0d part words (%0d rejected requests)",
               request_seen, parts_seen, reject_seen);
      $display("levels below the top visited %0d times over 19 shapes", deep_seen);
      if (fail_count == 0 && expected_parts.size() == 0) begin
         $display("nd_array_part_splitter_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d words never seen", fail_count,
                  expected_parts.size());
         $display("nd_array_part_splitter_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/spl_pkg.sv
sv/spl_dp.sv
sv/spl_ctrl.sv
sv/nd_array_part_splitter.sv
tb/nd_array_part_splitter_tb.sv
